### hw/rtl/dfvs_pkg.sv
package dfvs_pkg;

	localparam int unsigned NUM_VARIANTS = 9;
	localparam int unsigned IDX_W        = 4;
	localparam int unsigned SCORE_W      = 6;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VARIANTS - 1);

	// boot signature constants
	localparam logic [15:0] TRAILER_SIG     = 16'h55AA;
	localparam logic [23:0] HEADER_SIG      = 24'h444F53;
	localparam logic [15:0] TRAILER_MIN_LEN = 16'd510 + 16'd2;
	localparam logic [15:0] HEADER_MIN_LEN  = 16'd3;
	localparam logic [15:0] TYPE_MIN_LEN    = 16'd4;

	// weights, units of 0.05
	localparam logic [SCORE_W-1:0] W_TRACKS  = 6'd5;
	localparam logic [SCORE_W-1:0] W_HEADS   = 6'd5;
	localparam logic [SCORE_W-1:0] W_SPT     = 6'd4;
	localparam logic [SCORE_W-1:0] W_SSZ     = 6'd4;
	localparam logic [SCORE_W-1:0] W_BITRATE = 6'd1;
	localparam logic [SCORE_W-1:0] W_RPM     = 6'd1;
	localparam logic [SCORE_W-1:0] W_SIG     = 6'd7;
	localparam logic [SCORE_W-1:0] W_TYPE    = 6'd8;
	localparam logic [SCORE_W-1:0] W_TYPE0   = 6'd2;

	localparam logic [SCORE_W-1:0] LOW_LIMIT = 6'd8;
	localparam logic [SCORE_W-1:0] AMBIG_GAP = 6'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LOW      = 2'd1,
		ST_AMBIG    = 2'd2,
		ST_GEO_ONLY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SIG_NONE    = 2'd0,
		SIG_TRAILER = 2'd1,
		SIG_HEADER  = 2'd2
	} sig_kind_t;

	typedef struct packed {
		logic        geometry_present;
		logic [7:0]  tracks;
		logic [7:0]  heads;
		logic [7:0]  track_sectors;
		logic [15:0] bytes_per_sector;
		logic [19:0] bitrate;
		logic [9:0]  rpm;
		logic        boot_present;
		logic [15:0] boot_length;
		logic [31:0] boot_head_word;
		logic [15:0] boot_tail_word;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   variant_index;
		logic [SCORE_W-1:0] confidence;
		logic [1:0]         status;
		logic               accepted;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  trk;
		logic [7:0]  hds;
		logic [7:0]  spt;
		logic [15:0] ssz;
		logic [19:0] rate;
		logic [9:0]  spin;
		sig_kind_t   sig;
		logic        has_type;
		logic [7:0]  vol_type;
	} variant_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] idx;
		logic             finish;
	} dp_cmd_t;

	function automatic variant_t variant_rom(input logic [IDX_W-1:0] idx);
		variant_t v;
		unique case (idx)
			4'd0:    v = '{8'd40, 8'd2, 8'd9,  16'd512, 20'd250000, 10'd300,
				SIG_TRAILER, 1'b0, 8'd0};
			4'd1:    v = '{8'd80, 8'd2, 8'd9,  16'd512, 20'd250000, 10'd300,
				SIG_TRAILER, 1'b0, 8'd0};
			4'd2:    v = '{8'd80, 8'd2, 8'd15, 16'd512, 20'd500000, 10'd360,
				SIG_TRAILER, 1'b0, 8'd0};
			4'd3:    v = '{8'd80, 8'd2, 8'd18, 16'd512, 20'd500000, 10'd300,
				SIG_TRAILER, 1'b0, 8'd0};
			4'd4:    v = '{8'd80, 8'd2, 8'd11, 16'd512, 20'd250000, 10'd300,
				SIG_HEADER, 1'b1, 8'd0};
			4'd5:    v = '{8'd80, 8'd2, 8'd11, 16'd512, 20'd250000, 10'd300,
				SIG_HEADER, 1'b1, 8'd1};
			4'd6:    v = '{8'd80, 8'd2, 8'd11, 16'd512, 20'd250000, 10'd300,
				SIG_HEADER, 1'b1, 8'd2};
			4'd7:    v = '{8'd35, 8'd1, 8'd16, 16'd256, 20'd250000, 10'd300,
				SIG_NONE, 1'b0, 8'd0};
			4'd8:    v = '{8'd35, 8'd1, 8'd21, 16'd256, 20'd250000, 10'd300,
				SIG_NONE, 1'b0, 8'd0};
			default: v = '{8'd0, 8'd0, 8'd0, 16'd0, 20'd0, 10'd0,
				SIG_NONE, 1'b0, 8'd0};
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/dfvs_ctrl.sv
module dfvs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output dfvs_pkg::dp_cmd_t cmd
);
	import dfvs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCORE,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.load   = in_valid && (state_q == S_IDLE);
		cmd.step   = (state_q == S_SCORE);
		cmd.idx    = idx_q;
		cmd.finish = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCORE;
						idx_q   <= '0;
					end
				end
				S_SCORE: begin
					if (idx_q == LAST_IDX)
						state_q <= S_DONE;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// scan starts at the first table entry
	a_load_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (cmd.step && cmd.idx == '0))
		else $error("scan did not start at entry zero");

	// a result is never written over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result not presented");

endmodule

### hw/rtl/dfvs_datapath.sv
module dfvs_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  dfvs_pkg::dp_cmd_t  cmd,
	input  dfvs_pkg::in_item_t in_data,
	output dfvs_pkg::out_item_t out_data
);
	import dfvs_pkg::*;

	// captured item
	logic        geo_q;
	logic [7:0]  trk_q;
	logic [7:0]  hds_q;
	logic [7:0]  spt_q;
	logic [15:0] ssz_q;
	logic [19:0] rate_q;
	logic [9:0]  spin_q;
	logic        trailer_ok_q;
	logic        header_ok_q;
	logic        type_valid_q;
	logic [7:0]  vtype_q;

	// running best and second best
	logic [SCORE_W-1:0] best_q;
	logic [SCORE_W-1:0] second_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               best_mark_q;

	out_item_t out_q;

	variant_t           v;
	logic [SCORE_W-1:0] score;
	logic               mark;
	logic               hdr_ok;
	status_t            status;
	logic [SCORE_W-1:0] gap;

	assign hdr_ok = in_data.boot_present && (in_data.boot_length >= HEADER_MIN_LEN)
		&& (in_data.boot_head_word[31:8] == HEADER_SIG);

	always_comb begin
		v     = variant_rom(cmd.idx);
		score = '0;
		mark  = 1'b0;
		if (geo_q) begin
			if (trk_q == v.trk)   score = score + W_TRACKS;
			if (hds_q == v.hds)   score = score + W_HEADS;
			if (spt_q == v.spt)   score = score + W_SPT;
			if (ssz_q == v.ssz)   score = score + W_SSZ;
			if (rate_q == v.rate) score = score + W_BITRATE;
			if (spin_q == v.spin) score = score + W_RPM;
		end
		if ((v.sig == SIG_TRAILER && trailer_ok_q) || (v.sig == SIG_HEADER && header_ok_q)) begin
			score = score + W_SIG;
			mark  = 1'b1;
		end
		if (v.has_type && type_valid_q) begin
			if (v.vol_type == vtype_q) begin
				score = score + W_TYPE;
				mark  = 1'b1;
			end else if (v.vol_type == 8'd0) begin
				score = score + W_TYPE0;
			end
		end
	end

	always_comb begin
		gap = best_q - second_q;
		priority if (best_q < LOW_LIMIT)
			status = ST_LOW;
		else if (second_q != '0 && gap < AMBIG_GAP)
			status = ST_AMBIG;
		else if (!best_mark_q && geo_q)
			status = ST_GEO_ONLY;
		else
			status = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			geo_q        <= in_data.geometry_present;
			trk_q        <= in_data.tracks;
			hds_q        <= in_data.heads;
			spt_q        <= in_data.track_sectors;
			ssz_q        <= in_data.bytes_per_sector;
			rate_q       <= in_data.bitrate;
			spin_q       <= in_data.rpm;
			trailer_ok_q <= in_data.boot_present
				&& (in_data.boot_length >= TRAILER_MIN_LEN)
				&& (in_data.boot_tail_word == TRAILER_SIG);
			header_ok_q  <= hdr_ok;
			type_valid_q <= hdr_ok && (in_data.boot_length >= TYPE_MIN_LEN);
			vtype_q      <= in_data.boot_head_word[7:0];
			best_q       <= '0;
			second_q     <= '0;
			best_idx_q   <= '0;
			best_mark_q  <= 1'b0;
		end else if (cmd.step) begin
			// strictly greater wins, ties keep the earlier entry
			if (score > best_q) begin
				second_q    <= best_q;
				best_q      <= score;
				best_idx_q  <= cmd.idx;
				best_mark_q <= mark;
			end else if (score > second_q) begin
				second_q <= score;
			end
		end
		if (cmd.finish) begin
			out_q.found         <= (best_q != '0);
			out_q.variant_index <= best_idx_q;
			out_q.confidence    <= best_q;
			out_q.status        <= status;
			out_q.accepted      <= (status != ST_LOW);
		end
	end

	assign out_data = out_q;

	a_order_kept: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.step) |-> (best_q >= second_q))
		else $error("second best above best");

	a_found_conf: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.finish) |-> (out_q.found == (out_q.confidence != '0)))
		else $error("found flag disagrees with confidence");

	a_accept_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.finish) |-> (out_q.accepted == (out_q.status != ST_LOW)))
		else $error("accepted flag disagrees with status");

endmodule

### hw/rtl/disk_format_variant_scorer_core.sv
// operation: each accepted item is scored against the nine rom entries in turn
//   (nine scoring steps, then the decision state); the decision waits while a
//   previous result is still untaken. The single scoring unit walks the
//   rom one entry per cycle; a new item is accepted only back in idle
// reset: arst_n asynchronously clears the controller state and out_valid;
//   the datapath registers hold no reset value and are loaded per item
module disk_format_variant_scorer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dfvs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dfvs_pkg::out_item_t out_data
);
	import dfvs_pkg::*;

	// command bundle from the sequencer into the scoring datapath
	dp_cmd_t cmd;

	// sequencer: idle -> nine rom steps -> decision, waits while the
	// output register still holds an untaken transaction
	dfvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: captured item, per-entry scorer, best/second tracking,
	// status decision and the output register
	dfvs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule
